// File: hdl/awt_pkg.sv
// ----------------------------------------------------------------------------
// awt_pkg
// Shared types, codes and sizes of the address window translation table.
// ----------------------------------------------------------------------------
package awt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int ADDR_W = 64;
  localparam int LEN_W  = 48;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // words the block can hold at once: queue, back end, output register
  localparam int PIPE_CAPACITY = QUEUE_DEPTH + 2;

  // operation codes
  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_REMOVE    = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // classified command as it waits in the queue
  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] host_addr;
    logic [ADDR_W-1:0] device_base;
    logic [LEN_W-1:0]  span_bytes;
    logic              bad;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [ADDR_W-1:0] device_addr;
    logic [LEN_W-1:0]  region_length;
  } rsp_t;

  // one stored region record
  typedef struct packed {
    logic [ADDR_W-1:0] host_base;
    logic [ADDR_W-1:0] device_base;
    logic [LEN_W-1:0]  length;
  } entry_t;

endpackage

// File: hdl/awt_if.sv
// ----------------------------------------------------------------------------
// awt_if
// Request and response channels of the address window translation table.
// ----------------------------------------------------------------------------
interface awt_req_if;
  import awt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ADDR_W-1:0] host_addr;
  logic [ADDR_W-1:0] device_base;
  logic [LEN_W-1:0]  span_bytes;

  modport source (output valid, output op, output host_addr, output device_base,
                  output span_bytes, input ready);
  modport sink (input valid, input op, input host_addr, input device_base,
                input span_bytes, output ready);
endinterface

interface awt_rsp_if;
  import awt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              found;
  logic [ADDR_W-1:0] device_addr;
  logic [LEN_W-1:0]  region_length;

  modport source (output valid, output status, output found, output device_addr,
                  output region_length, input ready);
  modport sink (input valid, input status, input found, input device_addr,
                input region_length, output ready);
endinterface

// File: hdl/awt_front.sv
// ----------------------------------------------------------------------------
// awt_front
// Accepts request words and flags bad arguments before they are queued.
// ----------------------------------------------------------------------------
module awt_front (
  awt_req_if.sink        req,
  output logic           push,
  output awt_pkg::cmd_t  push_data,
  input  logic           full
);
  import awt_pkg::*;

  logic bad;

  // zero-argument checks per operation
  always_comb begin
    unique case (req.op)
      OP_INSERT: begin
        bad = (req.host_addr == '0) || (req.device_base == '0) || (req.span_bytes == '0);
      end
      OP_TRANSLATE: begin
        bad = (req.host_addr == '0) || (req.span_bytes == '0);
      end
      OP_REMOVE, OP_QUERY: begin
        bad = (req.host_addr == '0);
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // handshake into the queue
  assign req.ready = !full;
  assign push      = req.valid && !full;

  assign push_data.op          = req.op;
  assign push_data.host_addr   = req.host_addr;
  assign push_data.device_base = req.device_base;
  assign push_data.span_bytes  = req.span_bytes;
  assign push_data.bad         = bad;

endmodule

// File: hdl/awt_queue.sv
// ----------------------------------------------------------------------------
// awt_queue
// Short command queue that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module awt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  awt_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output awt_pkg::cmd_t  pop_data
);
  import awt_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/awt_back.sv
// ----------------------------------------------------------------------------
// awt_back
// Table engine: scans the region records one slot per cycle through a short
// pipeline, then updates the table and loads the response register.
// ----------------------------------------------------------------------------
module awt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  awt_pkg::cmd_t  q_data,
  output logic           pop,
  awt_rsp_if.source      rsp
);
  import awt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  cmd_t       cmd;

  // record memory and valid bits
  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [TABLE_ENTRIES-1:0] entry_valid;

  // scan pipeline
  logic [CNT_W-1:0]  issue_cnt;
  logic              issuing;
  logic              a_vld;
  logic [IDX_W-1:0]  a_idx;
  logic              b_vld;
  logic [IDX_W-1:0]  b_idx;
  logic              b_eq;
  logic              b_ge;
  logic [ADDR_W-1:0] b_off;
  logic [LEN_W-1:0]  b_len;
  logic [ADDR_W-1:0] b_dbase;
  logic              c_vld;
  logic [IDX_W-1:0]  c_idx;
  logic              c_eq;
  logic              c_ge;
  logic              c_lt;
  logic [LEN_W:0]    c_end;
  logic [LEN_W-1:0]  c_len;
  logic [ADDR_W-1:0] c_off;
  logic [ADDR_W-1:0] c_dbase;
  logic              c_vbit;
  logic              tr_match;
  logic              qy_match;

  // scan results
  logic              dup;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              hit;
  logic [ADDR_W-1:0] hit_off;
  logic [ADDR_W-1:0] hit_dbase;
  logic [LEN_W-1:0]  hit_len;

  // response
  logic out_vld;
  rsp_t out_data;
  rsp_t res;
  logic load;
  logic ins_ok;

  assign pop     = (state == S_IDLE) && q_valid;
  assign issuing = (state == S_SCAN) && (issue_cnt < CNT_W'(TABLE_ENTRIES));
  assign rd_addr = issue_cnt[IDX_W-1:0];
  assign load    = (state == S_FINISH) && (!out_vld || rsp.ready);
  assign wr_en   = load && ins_ok;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[free_idx] <= '{host_base: cmd.host_addr, device_base: cmd.device_base,
                         length: cmd.span_bytes};
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            issue_cnt <= '0;
            state     <= q_data.bad ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (c_vld && (c_idx == IDX_W'(TABLE_ENTRIES - 1))) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_data;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      a_vld <= issuing;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  // stage b: base compare and offset
  always_ff @(posedge clk) begin
    a_idx   <= rd_addr;
    b_idx   <= a_idx;
    b_eq    <= (rd_data.host_base == cmd.host_addr);
    b_ge    <= (cmd.host_addr >= rd_data.host_base);
    b_off   <= cmd.host_addr - rd_data.host_base;
    b_len   <= rd_data.length;
    b_dbase <= rd_data.device_base;
  end

  // stage c: offset inside region and end of requested span
  always_ff @(posedge clk) begin
    c_idx   <= b_idx;
    c_eq    <= b_eq;
    c_ge    <= b_ge;
    c_lt    <= (b_off[ADDR_W-1:LEN_W] == '0) && (b_off[LEN_W-1:0] < b_len);
    c_end   <= {1'b0, b_off[LEN_W-1:0]} + {1'b0, cmd.span_bytes};
    c_len   <= b_len;
    c_off   <= b_off;
    c_dbase <= b_dbase;
  end

  assign c_vbit   = entry_valid[c_idx];
  assign qy_match = c_vbit && c_ge && c_lt;
  assign tr_match = qy_match && (c_end <= {1'b0, c_len});

  // stage d: per-slot decision
  always_ff @(posedge clk) begin
    if (rst) begin
      dup        <= 1'b0;
      free_found <= 1'b0;
      hit        <= 1'b0;
    end else if (pop) begin
      dup        <= 1'b0;
      free_found <= 1'b0;
      hit        <= 1'b0;
    end else if (c_vld) begin
      unique case (cmd.op)
        OP_INSERT: begin
          if (c_vbit && c_eq) begin
            dup <= 1'b1;
          end
          if (!c_vbit && !free_found) begin
            free_found <= 1'b1;
          end
        end
        OP_REMOVE: begin
          if (c_vbit && c_eq) begin
            hit <= 1'b1;
          end
        end
        OP_TRANSLATE: begin
          if (!hit && tr_match) begin
            hit <= 1'b1;
          end
        end
        OP_QUERY: begin
          if (!hit && qy_match) begin
            hit <= 1'b1;
          end
        end
        default: begin
          hit <= hit;
        end
      endcase
    end
  end

  // captured data of the first match and free slot
  always_ff @(posedge clk) begin
    if (c_vld && (cmd.op == OP_INSERT) && !c_vbit && !free_found) begin
      free_idx <= c_idx;
    end
    if (c_vld && (cmd.op == OP_TRANSLATE) && !hit && tr_match) begin
      hit_off   <= c_off;
      hit_dbase <= c_dbase;
    end
    if (c_vld && (cmd.op == OP_QUERY) && !hit && qy_match) begin
      hit_len <= c_len;
    end
  end

  // valid bits: clear on remove hit, set on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else begin
      if (c_vld && (cmd.op == OP_REMOVE) && c_vbit && c_eq) begin
        entry_valid[c_idx] <= 1'b0;
      end
      if (wr_en) begin
        entry_valid[free_idx] <= 1'b1;
      end
    end
  end

  // result word
  always_comb begin
    res    = '0;
    ins_ok = 1'b0;
    if (cmd.bad) begin
      res.status = ST_BAD_ARG;
    end else begin
      unique case (cmd.op)
        OP_INSERT: begin
          priority if (dup) begin
            res.status = ST_DUP;
          end else if (!free_found) begin
            res.status = ST_FULL;
          end else begin
            res.status      = ST_OK;
            res.device_addr = cmd.device_base;
            ins_ok          = 1'b1;
          end
        end
        OP_REMOVE: begin
          res.found = hit;
        end
        OP_TRANSLATE: begin
          res.found = hit;
          if (hit) begin
            res.device_addr = hit_dbase + hit_off;
          end
        end
        OP_QUERY: begin
          res.found = hit;
          if (hit) begin
            res.region_length = hit_len;
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.status        = out_data.status;
  assign rsp.found         = out_data.found;
  assign rsp.device_addr   = out_data.device_addr;
  assign rsp.region_length = out_data.region_length;

endmodule

// File: hdl/address_window_translation_table_core.sv
// ----------------------------------------------------------------------------
// address_window_translation_table_core
// Region table mapping host address windows to device addresses.
// ----------------------------------------------------------------------------
// Each request word (insert, remove, translate, query) produces exactly one
// response word, in order. Requests are checked for zero arguments on entry
// and wait in a two-word command queue; the table engine then walks all
// TABLE_ENTRIES slots through its single read port, one slot per cycle,
// before it loads the response register, and a request rejected for a zero
// argument goes straight to the response register without a scan.
// The response register lets the engine start the next request while the
// previous word waits to be taken.
module address_window_translation_table_core (
  input  logic       clk,
  input  logic       rst,
  awt_req_if.sink    req,
  awt_rsp_if.source  rsp
);
  import awt_pkg::*;

  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_data;

  // request intake
  awt_front u_front (
    .req       (req),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  // command queue
  awt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // table engine
  awt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (q_pop),
    .rsp     (rsp)
  );

endmodule

// File: hdl/awt_checker.sv
// ----------------------------------------------------------------------------
// awt_checker
// Port-level checks of the translation table, bound to the top level.
// ----------------------------------------------------------------------------
module awt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [1:0]                 rsp_status,
  input logic                       rsp_found,
  input logic [awt_pkg::ADDR_W-1:0] rsp_device_addr,
  input logic [awt_pkg::LEN_W-1:0]  rsp_region_length
);
  import awt_pkg::*;

  localparam int OUT_W = $clog2(PIPE_CAPACITY + 2);

  logic [OUT_W-1:0] outstanding;
  logic             acc_in;
  logic             acc_out;

  assign acc_in  = req_valid && req_ready;
  assign acc_out = rsp_valid && rsp_ready;

  // words accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (acc_in && !acc_out) begin
      outstanding <= outstanding + 1'b1;
    end else if (acc_out && !acc_in) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  // never more words in flight than the block can hold
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= OUT_W'(PIPE_CAPACITY))
    else $error("more words in flight than the block can hold");

  // no response without a pending request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (outstanding != '0))
    else $error("response with no pending request");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found)
      && $stable(rsp_device_addr) && $stable(rsp_region_length))
    else $error("stalled response changed");

  // a match is always a clean status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> (rsp_status == ST_OK))
    else $error("match reported with error status");

  // a region length only comes with a query match
  a_len_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_region_length != '0) |-> rsp_found && (rsp_device_addr == '0))
    else $error("region length without a match");

endmodule

bind address_window_translation_table_core awt_checker u_awt_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_found         (rsp.found),
  .rsp_device_addr   (rsp.device_addr),
  .rsp_region_length (rsp.region_length)
);
